FILE: rtl/core/bcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types, codes and layout helpers for the bit-copy machine.
// ----------------------------------------------------------------------------
package bcm_pkg;

  localparam int DEF_MEM_BYTES  = 4096;
  localparam int DEF_SLOT_COUNT = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALTED  = 2'd1,
    ST_SRC_OOB = 2'd2,
    ST_DST_OOB = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_HALT,
    S_FRD,
    S_FWT,
    S_CHECK,
    S_SRD,
    S_SWT,
    S_DWT,
    S_RESP
  } state_t;

  // address field width: ceil(log2(space bits)) rounded up to whole bytes
  function automatic int addr_width(input int nbytes);
    int k;
    k = $clog2(nbytes * 8);
    k = ((k + 7) / 8) * 8;
    if (k < 8) k = 8;
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bit_copy_machine_tick_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bit_copy_machine_tick_top
// One-instruction bit-copy machine over a byte memory with read, write, tick.
// ----------------------------------------------------------------------------
// Copy: one memory port pair and one bit per read-modify-write set the
//   copy rate.
// Throughput: one word at a time; the next word is taken once the result
//   is in the output register.
// Reset: a clearing pass writes zero to all MEM_BYTES bytes, one a cycle,
//   and no word is taken until it ends.
module bit_copy_machine_tick_top
  import bcm_pkg::*;
#(
  parameter int MEM_BYTES  = DEF_MEM_BYTES,
  parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // operation[1:0], byte_address[13:2], byte_value[21:14]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata   // read_data[7:0], status[9:8], error_slot[13:10]
);

  localparam int MEM_BITS   = MEM_BYTES * 8;
  localparam int AW         = addr_width(MEM_BYTES);
  localparam int AB         = AW / 8;
  localparam int MAW        = $clog2(MEM_BYTES);
  localparam int SW         = $clog2(SLOT_COUNT);
  localparam int FPW        = $clog2(SLOT_COUNT * 3 * AB + 1);
  localparam int HALT_BYTE  = (SLOT_COUNT * 3 * AW + 6 * AW) / 8;
  localparam bit HALT_IN    = HALT_BYTE < MEM_BYTES;

  logic [7:0] mem [MEM_BYTES];

  state_t           state, state_next;
  logic [MAW-1:0]   clr;
  logic [MAW-1:0]   raddr, waddr;
  logic             re, we;
  logic [7:0]       wdata;
  logic [7:0]       rdata;
  logic             rd_ok;
  logic [FPW-1:0]   fptr;
  logic [1:0]       fidx;
  logic [1:0]       bcnt;
  logic [AW-1:0]    n_r, d_r, s_r;
  logic [AW-1:0]    sp, dp, cnt;
  logic             back;
  logic             bit_r;
  logic [SW-1:0]    slot;
  logic [7:0]       res_rd;
  status_t          res_st;
  logic [3:0]       res_slot;
  logic [1:0]       in_op;
  logic [11:0]      in_addr;
  logic [7:0]       in_val;
  logic             in_range;
  logic             fbyte_in;
  logic [7:0]       fbyte;
  logic [AW:0]      src_end, dst_end;
  logic             last_slot;

  assign in_op     = s_tdata[1:0];
  assign in_addr   = s_tdata[13:2];
  assign in_val    = s_tdata[21:14];
  assign in_range  = 32'(in_addr) < 32'(MEM_BYTES);
  assign fbyte_in  = 32'(fptr) < 32'(MEM_BYTES);
  assign fbyte     = rd_ok ? rdata : 8'd0;
  assign src_end   = {1'b0, s_r} + {1'b0, n_r};
  assign dst_end   = {1'b0, d_r} + {1'b0, n_r};
  assign last_slot = slot == SW'(SLOT_COUNT - 1);
  assign s_tready  = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
    rd_ok <= re;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        if (32'(clr) == 32'(MEM_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_op)
            OP_WRITE: begin
              we         = in_range;
              waddr      = MAW'(in_addr);
              wdata      = in_val;
              state_next = S_RESP;
            end
            OP_READ: begin
              re         = in_range;
              raddr      = MAW'(in_addr);
              state_next = S_READ;
            end
            OP_TICK: begin
              re         = HALT_IN;
              raddr      = MAW'(HALT_BYTE);
              state_next = S_HALT;
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_READ: state_next = S_RESP;
      S_HALT: state_next = (rd_ok && rdata[0]) ? S_RESP : S_FRD;
      S_FRD: begin
        re         = fbyte_in;
        raddr      = MAW'(fptr);
        state_next = S_FWT;
      end
      S_FWT: begin
        if (bcnt == 2'(AB - 1) && fidx == 2'd2) state_next = S_CHECK;
        else                                    state_next = S_FRD;
      end
      S_CHECK: begin
        if (n_r == '0)                                    state_next = last_slot ? S_RESP : S_FRD;
        else if (src_end > (AW + 1)'(MEM_BITS))           state_next = S_RESP;
        else if (dst_end > (AW + 1)'(MEM_BITS))           state_next = S_RESP;
        else                                              state_next = S_SRD;
      end
      S_SRD: begin
        re         = 1'b1;
        raddr      = sp[MAW+2:3];
        state_next = S_SWT;
      end
      S_SWT: begin
        re         = 1'b1;
        raddr      = dp[MAW+2:3];
        state_next = S_DWT;
      end
      S_DWT: begin
        we         = 1'b1;
        waddr      = dp[MAW+2:3];
        wdata      = rdata;
        wdata[~dp[2:0]] = bit_r;
        if (cnt == AW'(1)) state_next = last_slot ? S_RESP : S_FRD;
        else               state_next = S_SRD;
      end
      S_RESP: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_CLEAR) clr <= clr + MAW'(1);
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == S_RESP && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_rd   <= '0;
        res_st   <= ST_OK;
        res_slot <= '0;
        fptr     <= '0;
        fidx     <= '0;
        bcnt     <= '0;
        slot     <= '0;
      end
      S_READ: res_rd <= rd_ok ? rdata : 8'd0;
      S_HALT: if (rd_ok && rdata[0]) res_st <= ST_HALTED;
      S_FWT: begin
        fptr <= fptr + FPW'(1);
        case (fidx)
          2'd0:    n_r <= {n_r[AW-9:0], fbyte};
          2'd1:    d_r <= {d_r[AW-9:0], fbyte};
          default: s_r <= {s_r[AW-9:0], fbyte};
        endcase
        if (bcnt == 2'(AB - 1)) begin
          bcnt <= '0;
          fidx <= (fidx == 2'd2) ? 2'd0 : fidx + 2'd1;
        end else begin
          bcnt <= bcnt + 2'd1;
        end
      end
      S_CHECK: begin
        if (n_r == '0) begin
          slot <= slot + SW'(1);
        end else if (src_end > (AW + 1)'(MEM_BITS)) begin
          res_st   <= ST_SRC_OOB;
          res_slot <= 4'(slot);
        end else if (dst_end > (AW + 1)'(MEM_BITS)) begin
          res_st   <= ST_DST_OOB;
          res_slot <= 4'(slot);
        end else begin
          back <= d_r > s_r;
          sp   <= (d_r > s_r) ? s_r + n_r - AW'(1) : s_r;
          dp   <= (d_r > s_r) ? d_r + n_r - AW'(1) : d_r;
          cnt  <= n_r;
        end
      end
      S_SWT: bit_r <= rdata[~sp[2:0]];
      S_DWT: begin
        sp  <= back ? sp - AW'(1) : sp + AW'(1);
        dp  <= back ? dp - AW'(1) : dp + AW'(1);
        cnt <= cnt - AW'(1);
        if (cnt == AW'(1)) slot <= slot + SW'(1);
      end
      S_RESP: if (!m_tvalid || m_tready) m_tdata <= {2'b00, res_slot, res_st, res_rd};
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9:8] != 2'd0 |-> m_tdata[7:0] == 8'd0)
    else $error("read data with nonzero status");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13:10] != 4'd0 |-> m_tdata[9] == 1'b1)
    else $error("error slot without bounds error");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_SRD || state == S_SWT || state == S_DWT) |-> cnt != '0)
    else $error("copy running with zero count");

  assert property (@(posedge clk) $past(rst) |-> !s_tready)
    else $error("word taken before clear pass");

endmodule
`default_nettype wire

FILE: tb/tb_bit_copy_machine_tick_top.sv
// ----------------------------------------------------------------------------
// tb_bit_copy_machine_tick_top
// Stream-level checks of the bit-copy machine. A queue of byte writes, reads
// and ticks feeds a bursty driver. A bit-level memory image predicts every
// result word. A monitor compares status, read data and error slot under a
// randomly stalling receiver, with one long stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_bit_copy_machine_tick_top;
  import bcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPACE     = DEF_MEM_BYTES;
  localparam int SLOTS     = DEF_SLOT_COUNT;
  localparam int ABITS     = 16;
  localparam int SPACE_BIT = SPACE * 8;
  localparam int HALT_POS  = SLOTS * 3 * ABITS + 7 + 6 * ABITS;
  localparam int HALT_BYTE = HALT_POS / 8;
  localparam int NUM_WORDS = 1300;
  localparam int IDLE_MAX  = 8000000;

  typedef struct packed {
    op_t        op;
    logic [11:0] addr;
    logic [7:0]  val;
  } cmd_t;

  typedef struct packed {
    logic [7:0] rd;
    status_t    st;
    logic [3:0] slot;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  bit_copy_machine_tick_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  logic [7:0] image [SPACE];
  cmd_t       cmd_q[$];
  resp_t      resp_q[$];
  int         errors = 0;
  int         n_ticks = 0, n_halted = 0, n_oob = 0, n_words = 0;
  int         pushed = 0;

  function automatic bit img_bit(int p);
    if (p >= SPACE_BIT) return 1'b0;
    return image[p >> 3][7 - (p & 7)];
  endfunction

  function automatic void img_put(int p, bit v);
    if (p < SPACE_BIT) image[p >> 3][7 - (p & 7)] = v;
  endfunction

  function automatic int img_field(int p);
    int v;
    v = 0;
    for (int i = 0; i < ABITS; i++) v = (v << 1) | img_bit(p + i);
    return v;
  endfunction

  function automatic void run_tick(output status_t st, output logic [3:0] slot);
    int n, dst, src, base;
    st = ST_OK;
    slot = '0;
    if (img_bit(HALT_POS)) begin
      st = ST_HALTED;
      return;
    end
    for (int s = 0; s < SLOTS; s++) begin
      base = s * 3 * ABITS;
      n = img_field(base);
      dst = img_field(base + ABITS);
      src = img_field(base + 2 * ABITS);
      if (n == 0) continue;
      if (src + n > SPACE_BIT) begin
        st = ST_SRC_OOB;
        slot = s[3:0];
        return;
      end
      if (dst + n > SPACE_BIT) begin
        st = ST_DST_OOB;
        slot = s[3:0];
        return;
      end
      if (dst > src) begin
        for (int i = n - 1; i >= 0; i--) img_put(dst + i, img_bit(src + i));
      end else begin
        for (int i = 0; i < n; i++) img_put(dst + i, img_bit(src + i));
      end
    end
  endfunction

  function automatic resp_t predict_word(cmd_t c);
    resp_t r;
    r = '{rd: 8'h00, st: ST_OK, slot: 4'h0};
    case (c.op)
      OP_WRITE: begin
        if (c.addr < SPACE) image[c.addr] = c.val;
      end
      OP_READ: begin
        if (c.addr < SPACE) r.rd = image[c.addr];
      end
      OP_TICK: begin
        run_tick(r.st, r.slot);
        n_ticks++;
        if (r.st == ST_HALTED) n_halted++;
        if (r.st == ST_SRC_OOB || r.st == ST_DST_OOB) n_oob++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push(op_t op, int addr, int val);
    cmd_q.push_back('{op: op, addr: addr[11:0], val: val[7:0]});
    pushed++;
  endtask

  task automatic set_slot(int s, int n, int dst, int src);
    int b;
    b = s * 6;
    push(OP_WRITE, b,     n >> 8);
    push(OP_WRITE, b + 1, n & 8'hFF);
    push(OP_WRITE, b + 2, dst >> 8);
    push(OP_WRITE, b + 3, dst & 8'hFF);
    push(OP_WRITE, b + 4, src >> 8);
    push(OP_WRITE, b + 5, src & 8'hFF);
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || resp_q.size() != 0) @(posedge clk);
  endtask

  // driver: bursts with random gaps
  logic accepted = 1'b0;
  int   burst_left = 0, gap_left = 0;

  always @(posedge clk) begin
    accepted <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      resp_q.push_back(predict_word(cmd_q.pop_front()));
      n_words++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !accepted) begin
      s_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      s_tvalid <= 1'b0;
    end else if (cmd_q.size() != 0) begin
      s_tvalid <= 1'b1;
      s_tdata <= {2'b00, cmd_q[0].val, cmd_q[0].addr, cmd_q[0].op};
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int cyc = 0, hold_left = 0;
  bit held = 1'b0;

  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!held && cyc > 6000 && cmd_q.size() > 4) begin
      held <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if ((cyc / 200) % 3 == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor and watchdog
  int idle = 0;

  always @(posedge clk) begin
    resp_t e;
    if (m_tvalid && m_tready) begin
      if (resp_q.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (m_tdata[7:0] !== e.rd) begin
          $error("read_data expected %h actual %h", e.rd, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[9:8] !== e.st) begin
          $error("status expected %0d actual %0d", e.st, m_tdata[9:8]);
          errors++;
        end
        if (m_tdata[13:10] !== e.slot) begin
          $error("error_slot expected %0d actual %0d", e.slot, m_tdata[13:10]);
          errors++;
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle <= 0;
    else idle <= idle + 1;
    if (idle >= IDLE_MAX) begin
      $display("timeout after %0d idle cycles", idle);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int n, dst, src, k;
    for (int i = 0; i < SPACE; i++) image[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed
    push(OP_WRITE, 0, 8'hFF);
    push(OP_WRITE, 4095, 8'hA5);
    push(OP_READ, 4095, 0);
    push(OP_NONE, 4095, 8'hFF);
    push(OP_TICK, 0, 0);
    push(OP_READ, 0, 0);
    set_slot(0, 8, SPACE_BIT - 8, SPACE_BIT - 8 * 12);
    set_slot(1, 16, SPACE_BIT - 15, 4000);
    push(OP_TICK, 0, 0);
    push(OP_READ, 4095, 0);
    set_slot(1, 12, 8004, 8000);
    set_slot(2, 12, 9000, 9004);
    set_slot(3, 8, 3 * 48 + 8, 0);
    push(OP_WRITE, 1000, 8'h3C);
    push(OP_WRITE, 1125, 8'hC3);
    push(OP_TICK, 0, 0);
    push(OP_READ, 1000, 0);
    push(OP_READ, 1001, 0);
    push(OP_READ, 1125, 0);
    push(OP_WRITE, HALT_BYTE, 8'h01);
    push(OP_TICK, 0, 0);
    push(OP_WRITE, HALT_BYTE, 8'hFE);
    push(OP_TICK, 0, 0);
    drain();

    // random programs
    while (pushed < NUM_WORDS) begin
      for (int s = 0; s < SLOTS; s++) begin
        if ($urandom_range(0, 99) < 35) begin
          k = $urandom_range(0, 99);
          n = (k < 5) ? 0 : (k < 8) ? $urandom_range(200, 2000) : $urandom_range(1, 40);
          if ($urandom_range(0, 9) == 0)
            dst = $urandom_range(0, SPACE_BIT - 1 - n);
          else
            dst = $urandom_range(8 * 112, SPACE_BIT - n);
          src = $urandom_range(0, SPACE_BIT - n);
          k = $urandom_range(0, 99);
          if (k < 4) src = $urandom_range(SPACE_BIT - n + 1, 65535);
          else if (k < 8) dst = $urandom_range(SPACE_BIT - n + 1, 65535);
          set_slot(s, n, dst, src);
        end else if (img_field(s * 3 * ABITS) != 0) begin
          push(OP_WRITE, s * 6, 0);
          push(OP_WRITE, s * 6 + 1, 0);
        end
      end
      push(OP_WRITE, HALT_BYTE,
           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) | 1
                                       : $urandom_range(0, 255) & 8'hFE);
      for (int j = $urandom_range(0, 6); j > 0; j--) begin
        k = $urandom_range(0, 9);
        if (k < 4) push(OP_WRITE, $urandom_range(112, 4095), $urandom_range(0, 255));
        else if (k < 8) push(OP_READ, $urandom_range(0, 4095), 0);
        else push(OP_NONE, $urandom_range(0, 4095), $urandom_range(0, 255));
      end
      push(OP_TICK, 0, 0);
      if ($urandom_range(0, 3) == 0) push(OP_TICK, 0, 0);
      for (int j = $urandom_range(2, 8); j > 0; j--)
        push(OP_READ, $urandom_range(0, 4095), 0);
      drain();
    end

    repeat (200) @(posedge clk);
    $display("words %0d, ticks %0d (halted %0d, bounds errors %0d)",
             n_words, n_ticks, n_halted, n_oob);
    if (errors == 0 && resp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bcm_pkg.sv
rtl/core/bit_copy_machine_tick_top.sv
tb/tb_bit_copy_machine_tick_top.sv
